[rtl/homogeneous_point_transform_unit_assert.svh]
// Assertion macros used by the checker of this block.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPT_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HPT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/hpt_pkg.sv]
`default_nettype none

package hpt_pkg;

	// Width of one multiplier digit taken from a coordinate per cycle.
	localparam int DIGIT_W = 16;

	// Matrix store geometry: four rows of four entries.
	localparam int MAT_DEPTH = 16;
	localparam int MAT_AW    = 4;

	// Transform mode register codes; the reserved code behaves as the 4x4 mode.
	localparam logic [1:0] MODE_PROJ  = 2'd1;
	localparam logic [1:0] MODE_HOMOG = 2'd2;

	// Kind of an input transaction.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_POINT = 1'b1;

	// Result status.
	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_W_ZERO = 2'd1,
		STATUS_SAT    = 2'd2
	} status_t;

endpackage

`default_nettype wire

[rtl/hpt_ram.sv]
`default_nettype none

module hpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/homogeneous_point_transform_unit.sv]
// A matrix write transaction is taken while idle and gives no result. A point transaction
// reads and multiplies each coordinate term digit by digit, adds the homogeneous term and
// closes each row; each divided component is checked for overflow, divided bit by bit and
// rounded (the divider is skipped if the quotient overflows); the result is then registered.
// One point at a time; the next transaction is taken only after the result is registered.
// Reset clears the control state and the mode register; the matrix store is not cleared.
`default_nettype none

module homogeneous_point_transform_unit
	import hpt_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic s_tvalid,
	output logic      s_tready,
	// entry_index, entry_value, coord_x, coord_y, coord_z, zero padding
	input  wire logic [((4 * COORD_WIDTH + 4 + 7) / 8) * 8 - 1:0] s_tdata,
	// req_type
	input  wire logic s_tuser,

	output logic      m_tvalid,
	input  wire logic m_tready,
	// out_x, out_y, out_z, zero padding
	output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// status
	output logic [1:0] m_tuser,

	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata
);

	localparam int CW       = COORD_WIDTH;
	localparam int M_DATA_W = ((3 * CW + 7) / 8) * 8;
	localparam int NDIG     = (CW + DIGIT_W - 1) / DIGIT_W;
	localparam int MB_W     = NDIG * DIGIT_W;
	localparam int DGI_W    = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int PROD_W   = CW + DIGIT_W + 1;
	localparam int SH_MAX   = (DIGIT_W * (NDIG - 1) > FRAC_BITS) ?
		DIGIT_W * (NDIG - 1) : FRAC_BITS;
	localparam int SH_W     = $clog2(SH_MAX + 1);
	localparam int SUM_W    = ((2 * CW > CW + FRAC_BITS + 1) ? 2 * CW : CW + FRAC_BITS + 1) + 2;
	localparam int DIVD_W   = SUM_W + FRAC_BITS;
	localparam int HI_W     = DIVD_W - CW;
	localparam int R_W      = ((HI_W > SUM_W) ? HI_W : SUM_W) + 1;
	localparam int CNT_W    = $clog2(CW);

	localparam logic [CW:0]   MAG_LIM = {1'b0, 1'b1, {(CW - 1){1'b0}}};
	localparam logic [CW:0]   MAG_POS = {2'b00, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] SAT_NEG = {1'b1, {(CW - 1){1'b0}}};
	localparam logic [CW-1:0] SAT_POS = {1'b0, {(CW - 1){1'b1}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_TERM,
		ST_ROW,
		ST_DCHK,
		ST_DIV,
		ST_ROUND,
		ST_COMP,
		ST_DONE
	} state_t;

	// Control state.
	state_t            state_q;
	logic [1:0]        mode_q;
	logic              w_done_q;
	logic [1:0]        col_q;
	logic [1:0]        comp_q;
	logic [DGI_W-1:0]  dig_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              prod_v_q;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	status_t           m_tuser_q;

	// Datapath registers.
	logic signed [CW-1:0]     x_q, y_q, z_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [SH_W-1:0]          prod_sh_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]         den_q;
	logic                     wsign_q;
	logic                     neg_q;
	logic [R_W-1:0]           rem_q;
	logic [CW-1:0]            lo_q;
	logic [CW-1:0]            q_q;
	logic                     sat_q;
	logic                     wz_q;
	logic [CW-1:0]            res_x_q, res_y_q, res_z_q;

	// Input fields.
	logic [MAT_AW-1:0] in_index;
	logic [CW-1:0]     in_value;
	logic signed [CW-1:0] in_x, in_y, in_z;
	logic s_accept;

	assign in_index = s_tdata[MAT_AW-1:0];
	assign in_value = s_tdata[MAT_AW +: CW];
	assign in_x     = s_tdata[MAT_AW + CW +: CW];
	assign in_y     = s_tdata[MAT_AW + 2 * CW +: CW];
	assign in_z     = s_tdata[MAT_AW + 3 * CW +: CW];

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// Row and column bounds for the selected mode.
	logic [1:0] last_col, w_row, last_comp, cur_row;

	always_comb begin
		case (mode_q)
			MODE_HOMOG: begin
				last_col  = 2'd2;
				w_row     = 2'd2;
				last_comp = 2'd1;
			end
			MODE_PROJ: begin
				last_col  = 2'd3;
				w_row     = 2'd2;
				last_comp = 2'd1;
			end
			default: begin
				last_col  = 2'd3;
				w_row     = 2'd3;
				last_comp = 2'd2;
			end
		endcase
	end

	assign cur_row = w_done_q ? comp_q : w_row;

	// Matrix store.
	logic [CW-1:0] ram_rdata;

	hpt_ram #(
		.WIDTH(CW),
		.DEPTH(MAT_DEPTH)
	) u_hpt_ram (
		.clk  (clk),
		.we   (s_accept && (s_tuser == REQ_WRITE)),
		.waddr(in_index),
		.wdata(in_value),
		.re   (state_q == ST_READ),
		.raddr({cur_row, col_q}),
		.rdata(ram_rdata)
	);

	// Digit multiplier: matrix entry times one 16-bit digit of the coordinate.
	logic signed [CW-1:0]      ent_s;
	logic signed [CW-1:0]      coord;
	logic signed [MB_W-1:0]    coord_ext;
	logic [DIGIT_W-1:0]        digit;
	logic signed [DIGIT_W:0]   digit_s;
	logic signed [PROD_W-1:0]  mul_p;
	logic                      homog_col;
	logic                      dig_last;

	assign ent_s     = ram_rdata;
	assign coord     = (col_q == 2'd0) ? x_q : ((col_q == 2'd1) ? y_q : z_q);
	assign coord_ext = MB_W'(coord);
	assign digit     = coord_ext[dig_q * DIGIT_W +: DIGIT_W];
	assign dig_last  = (dig_q == DGI_W'(NDIG - 1));
	assign digit_s   = dig_last ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
	assign mul_p     = ent_s * digit_s;
	assign homog_col = (col_q == last_col);

	// Shifted partial product for the row accumulator.
	logic signed [SUM_W-1:0] addend;
	assign addend = SUM_W'(prod_q) <<< prod_sh_q;

	// Magnitude of the finished row sum and the scaled dividend.
	logic [SUM_W-1:0]  acc_mag;
	logic [DIVD_W-1:0] dividend;
	logic [R_W-1:0]    den_ext;

	assign acc_mag  = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
	assign dividend = {acc_mag, {FRAC_BITS{1'b0}}};
	assign den_ext  = R_W'(den_q);

	// Restoring divider step and overflow check on the leading part.
	logic [R_W-1:0] div_r2;
	logic           div_ge;
	logic           div_ovf;

	assign div_r2  = {rem_q[R_W-2:0], lo_q[CW-1]};
	assign div_ge  = (div_r2 >= den_ext);
	assign div_ovf = (rem_q >= den_ext);

	// Round half away from zero, then clamp.
	logic [R_W-1:0] rnd_r2;
	logic           rnd_up;
	logic [CW:0]    rnd_q;
	logic [CW:0]    max_mag;
	logic           rnd_sat;
	logic [CW-1:0]  rnd_mag;
	logic [CW-1:0]  rnd_val;
	logic [CW-1:0]  res_val;

	assign rnd_r2  = {rem_q[R_W-2:0], 1'b0};
	assign rnd_up  = (rnd_r2 >= den_ext);
	assign rnd_q   = {1'b0, q_q} + {{CW{1'b0}}, rnd_up};
	assign max_mag = neg_q ? MAG_LIM : MAG_POS;
	assign rnd_sat = (rnd_q > max_mag);
	assign rnd_mag = rnd_sat ? max_mag[CW-1:0] : rnd_q[CW-1:0];
	assign rnd_val = neg_q ? (-rnd_mag) : rnd_mag;
	assign res_val = (state_q == ST_DCHK) ? (neg_q ? SAT_NEG : SAT_POS) : rnd_val;

	// Sequencer, mode register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= '0;
			w_done_q   <= 1'b0;
			col_q      <= '0;
			comp_q     <= '0;
			dig_q      <= '0;
			cnt_q      <= '0;
			prod_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= STATUS_OK;
		end else begin
			prod_v_q <= (state_q == ST_MUL);
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept && (s_tuser == REQ_POINT)) begin
						w_done_q <= 1'b0;
						col_q    <= '0;
						comp_q   <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					dig_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (homog_col || dig_last) begin
						state_q <= ST_TERM;
					end else begin
						dig_q <= dig_q + 1'b1;
					end
				end
				ST_TERM: begin
					if (homog_col) begin
						state_q <= ST_ROW;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_ROW: begin
					col_q <= '0;
					if (!w_done_q) begin
						if (acc_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							w_done_q <= 1'b1;
							state_q  <= ST_READ;
						end
					end else begin
						state_q <= ST_DCHK;
					end
				end
				ST_DCHK: begin
					cnt_q   <= '0;
					state_q <= div_ovf ? ST_COMP : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CW - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					if (comp_q == last_comp) begin
						state_q <= ST_DONE;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_DATA_W'({res_z_q, res_y_q, res_x_q});
						m_tuser_q  <= wz_q ? STATUS_W_ZERO : (sat_q ? STATUS_SAT : STATUS_OK);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Accumulator, divider and result registers.
	always_ff @(posedge clk) begin
		if (prod_v_q) begin
			acc_q <= acc_q + addend;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_accept && (s_tuser == REQ_POINT)) begin
					x_q     <= in_x;
					y_q     <= in_y;
					z_q     <= in_z;
					acc_q   <= '0;
					sat_q   <= 1'b0;
					wz_q    <= 1'b0;
					res_x_q <= '0;
					res_y_q <= '0;
					res_z_q <= '0;
				end
			end
			ST_MUL: begin
				if (homog_col) begin
					prod_q    <= PROD_W'(ent_s);
					prod_sh_q <= SH_W'(FRAC_BITS);
				end else begin
					prod_q    <= mul_p;
					prod_sh_q <= SH_W'(dig_q * DIGIT_W);
				end
			end
			ST_ROW: begin
				acc_q <= '0;
				if (!w_done_q) begin
					den_q   <= acc_mag;
					wsign_q <= acc_q[SUM_W-1];
					wz_q    <= (acc_q == '0);
				end else begin
					neg_q <= acc_q[SUM_W-1] ^ wsign_q;
					rem_q <= R_W'(dividend[DIVD_W-1:CW]);
					lo_q  <= dividend[CW-1:0];
					q_q   <= '0;
				end
			end
			ST_DCHK, ST_ROUND: begin
				if ((state_q == ST_ROUND) || div_ovf) begin
					if ((state_q == ST_DCHK) || rnd_sat) begin
						sat_q <= 1'b1;
					end
					case (comp_q)
						2'd0:    res_x_q <= res_val;
						2'd1:    res_y_q <= res_val;
						default: res_z_q <= res_val;
					endcase
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? (div_r2 - den_ext) : div_r2;
				q_q   <= {q_q[CW-2:0], div_ge};
				lo_q  <= {lo_q[CW-2:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

[rtl/hpt_checker.sv]
`default_nettype none

`include "homogeneous_point_transform_unit_assert.svh"

module hpt_checker
	import hpt_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	// req_type
	input wire logic s_tuser,
	input wire logic m_tvalid,
	input wire logic m_tready,
	// out_x, out_y, out_z, zero padding
	input wire logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// status
	input wire logic [1:0] m_tuser
);

	// A zero homogeneous component gives an all-zero point.
	`HPT_ASSERT_SAME(a_wzero_data, clk, arst_n, m_tvalid && (m_tuser == STATUS_W_ZERO), m_tdata == '0, "w zero result carries data")

	// A point transaction keeps the block busy for at least the next cycle.
	`HPT_ASSERT_NEXT(a_point_busy, clk, arst_n, s_tvalid && s_tready && (s_tuser == REQ_POINT), !s_tready, "ready after point transaction")

	// A matrix write transaction never raises a result.
	`HPT_ASSERT_NEXT(a_write_silent, clk, arst_n, s_tvalid && s_tready && (s_tuser == REQ_WRITE) && !m_tvalid, !m_tvalid, "result after matrix write")

	// A stalled result holds.
	`HPT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind homogeneous_point_transform_unit hpt_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_hpt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import hpt_pkg::*;

	localparam int CW          = 32;
	localparam int FRAC        = 16;
	localparam int S_W         = ((4 * CW + 4 + 7) / 8) * 8;
	localparam int M_W         = ((3 * CW + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 2_000_000;
	// Comfortably longer than the slowest point transaction.
	localparam int SETTLE      = 200;

	// Mode codes that the package leaves unnamed.
	localparam logic [1:0] MODE_XFORM3D  = 2'd0;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	localparam logic [CW-1:0] Q_ONE = 32'h0001_0000;
	localparam logic [CW-1:0] Q_TWO = 32'h0002_0000;
	localparam logic [CW-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [CW-1:0] Q_MIN = 32'h8000_0000;

	// Mode used by each random phase, phase 0 in the lowest bits.
	localparam logic [5:0][1:0] MODE_PLAN = {MODE_PROJ, MODE_XFORM3D, MODE_RESERVED,
		MODE_HOMOG, MODE_PROJ, MODE_XFORM3D};

	typedef struct {
		logic          kind;
		logic [3:0]    index;
		logic [CW-1:0] value;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} transform_req_t;

	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		status_t       status;
	} point_result_t;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           s_tvalid  = 1'b0;
	logic           s_tready;
	logic [S_W-1:0] s_tdata   = '0;
	logic           s_tuser   = 1'b0;
	logic           m_tvalid;
	logic           m_tready  = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic [1:0]     m_tuser;
	logic           cfg_we    = 1'b0;
	logic [1:0]     cfg_wdata = 2'd0;

	// Shadow of the block's matrix and mode register.
	logic signed [CW-1:0] matrix_copy [16];
	logic [1:0]           mode_copy = MODE_XFORM3D;

	transform_req_t request_queue [$];
	point_result_t  awaited_points [$];
	transform_req_t in_flight;
	int             tx_idle_pct = 0;
	int             rx_idle_pct = 0;
	int             mismatch_count = 0;
	int             cycle_count = 0;

	homogeneous_point_transform_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Exact dot product of one matrix row with the extended point.
	function automatic logic signed [127:0] row_total(int row, logic signed [127:0] v0,
		logic signed [127:0] v1, logic signed [127:0] v2, logic signed [127:0] v3, int ncols);
		logic signed [127:0] acc;
		logic signed [127:0] term [4];
		int                  c;
		term[0] = v0;
		term[1] = v1;
		term[2] = v2;
		term[3] = v3;
		acc = '0;
		for (c = 0; c < ncols; c++)
			acc = acc + matrix_copy[row * 4 + c] * term[c];
		return acc;
	endfunction

	// Divides a row sum by w, rounding half away from zero, then clamps.
	function automatic logic [CW-1:0] dehomogenise(logic signed [127:0] num,
		logic signed [127:0] den, output logic clamped);
		logic         negative;
		logic [127:0] mag_num;
		logic [127:0] mag_den;
		logic [127:0] quo;
		logic [127:0] rem;
		logic [127:0] ceiling;
		negative = num[127] ^ den[127];
		mag_num = num[127] ? -num : num;
		mag_den = den[127] ? -den : den;
		mag_num = mag_num << FRAC;
		quo = mag_num / mag_den;
		rem = mag_num % mag_den;
		if ((rem << 1) >= mag_den)
			quo = quo + 1;
		ceiling = negative ? (128'd1 << (CW - 1)) : (128'd1 << (CW - 1)) - 1;
		clamped = quo > ceiling;
		if (clamped)
			quo = ceiling;
		return negative ? -quo[CW-1:0] : quo[CW-1:0];
	endfunction

	// Expected result of one point under the current mode and matrix.
	function automatic point_result_t transform_point(transform_req_t req);
		point_result_t       res;
		logic signed [127:0] px;
		logic signed [127:0] py;
		logic signed [127:0] v2;
		logic signed [127:0] v3;
		logic signed [127:0] unit;
		logic signed [127:0] w_sum;
		logic [CW-1:0]       outs [3];
		logic                clamped;
		logic                any_clamp;
		int                  ncols;
		int                  nout;
		int                  wrow;
		int                  k;
		unit = 128'sd1 <<< FRAC;
		px = $signed(req.x);
		py = $signed(req.y);
		case (mode_copy)
			MODE_HOMOG: begin
				v2 = unit;
				v3 = '0;
				ncols = 3;
				nout = 2;
				wrow = 2;
			end
			MODE_PROJ: begin
				v2 = $signed(req.z);
				v3 = unit;
				ncols = 4;
				nout = 2;
				wrow = 2;
			end
			default: begin
				v2 = $signed(req.z);
				v3 = unit;
				ncols = 4;
				nout = 3;
				wrow = 3;
			end
		endcase
		outs[0] = '0;
		outs[1] = '0;
		outs[2] = '0;
		any_clamp = 1'b0;
		w_sum = row_total(wrow, px, py, v2, v3, ncols);
		if (w_sum == 0) begin
			res.status = STATUS_W_ZERO;
		end else begin
			for (k = 0; k < nout; k++) begin
				outs[k] = dehomogenise(row_total(k, px, py, v2, v3, ncols), w_sum, clamped);
				any_clamp |= clamped;
			end
			res.status = any_clamp ? STATUS_SAT : STATUS_OK;
		end
		res.x = outs[0];
		res.y = outs[1];
		res.z = outs[2];
		return res;
	endfunction

	// Q16.16 value: mostly moderate, with zeros, units, extremes and raw bits.
	function automatic logic [CW-1:0] random_q16(int mag_bits);
		logic [CW-1:0] span;
		span = 32'd1 << mag_bits;
		case ($urandom_range(9))
			0, 1: return '0;
			7: return $urandom;
			8: return $urandom_range(1) ? Q_ONE : -Q_ONE;
			9: return $urandom_range(1) ? Q_MAX : Q_MIN;
			default: return $urandom_range(2 * span - 1) - span;
		endcase
	endfunction

	task automatic queue_write(logic [3:0] index, logic [CW-1:0] value);
		transform_req_t req;
		req.kind = REQ_WRITE;
		req.index = index;
		req.value = value;
		req.x = $urandom;
		req.y = $urandom;
		req.z = $urandom;
		request_queue.push_back(req);
	endtask

	task automatic queue_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		transform_req_t req;
		req.kind = REQ_POINT;
		req.index = 4'($urandom);
		req.value = $urandom;
		req.x = x;
		req.y = y;
		req.z = z;
		request_queue.push_back(req);
	endtask

	// Random mix of matrix updates and points, some of them at the origin.
	task automatic queue_random(int count);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < 25)
				queue_write(4'($urandom_range(15)), random_q16(18));
			else if ($urandom_range(99) < 5)
				queue_point('0, '0, '0);
			else
				queue_point(random_q16(24), random_q16(24), random_q16(24));
		end
	endtask

	// Sampled on the falling edge so that the driver and monitor have settled.
	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || s_tvalid || awaited_points.size() != 0);
	endtask

	task automatic write_mode(logic [1:0] mode);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		mode_copy  = mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic flag_error(string text);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", text);
	endtask

	// Driver: predicts each accepted transaction and presents the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (in_flight.kind == REQ_WRITE)
					matrix_copy[in_flight.index] = in_flight.value;
				else
					awaited_points.push_back(transform_point(in_flight));
			end
			if (!s_tvalid || s_tready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					in_flight = request_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= in_flight.kind;
					s_tdata  <= {4'b0, in_flight.z, in_flight.y, in_flight.x,
						in_flight.value, in_flight.index};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls the result stream at random and checks every result.
	always @(posedge clk) begin
		point_result_t want;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
			if (m_tvalid && m_tready) begin
				if (awaited_points.size() == 0) begin
					flag_error($sformatf("Result with no point pending: x=%h y=%h z=%h status=%0d",
						m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tdata[3*CW-1:2*CW], m_tuser));
				end else begin
					want = awaited_points.pop_front();
					if (m_tdata[CW-1:0] !== want.x || m_tdata[2*CW-1:CW] !== want.y ||
						m_tdata[3*CW-1:2*CW] !== want.z || m_tuser !== want.status) begin
						flag_error($sformatf({"Mismatch: expected x=%h y=%h z=%h status=%0d, ",
							"got x=%h y=%h z=%h status=%0d"}, want.x, want.y, want.z,
							want.status, m_tdata[CW-1:0], m_tdata[2*CW-1:CW],
							m_tdata[3*CW-1:2*CW], m_tuser));
					end
				end
			end
		end
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int i;
		int p;
		tx_idle_pct = 16;
		rx_idle_pct = 48;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Load the whole matrix: unit diagonal, full-scale translations in x and y.
		for (i = 0; i < 16; i++)
			queue_write(4'(i), (i % 5 == 0) ? Q_ONE : (i == 3) ? Q_MAX : (i == 7) ? Q_MIN : '0);
		// Origin maps exactly onto the extremes; any offset then clamps.
		queue_point('0, '0, '0);
		queue_point(Q_ONE, -Q_ONE, '0);
		queue_point(Q_MAX, Q_MIN, Q_MAX);
		wait_for_drain();

		// With w at 2.0 a coordinate of one LSB lands exactly half-way; z is unused.
		write_mode(MODE_HOMOG);
		queue_write(4'd10, Q_TWO);
		queue_point(32'd1, -32'd1, 32'h5a5a_5a5a);
		wait_for_drain();

		// Clearing row two leaves the projection with a zero weight.
		write_mode(MODE_PROJ);
		queue_write(4'd10, '0);
		queue_point(Q_ONE, Q_TWO, -Q_ONE);
		wait_for_drain();

		// The reserved code must behave as the full 3D transform.
		write_mode(MODE_RESERVED);
		queue_point(Q_ONE, Q_TWO, -Q_ONE);
		queue_point('0, '0, '0);
		wait_for_drain();

		// Random phases, each split by a full drain of the pipeline.
		for (p = 0; p < 6; p++) begin
			tx_idle_pct = (p < 2) ? 16 : (p < 4) ? 48 : 0;
			rx_idle_pct = (p < 2) ? 48 : (p < 4) ? 16 : 0;
			write_mode(MODE_PLAN[p]);
			queue_random(156);
			wait_for_drain();
			queue_random(156);
			wait_for_drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
